### hdl/mie_pkg.sv
// Package for the modular inverse block: FSM state type, controller command and
// datapath status structures, field widths and register map constants.
// No dependencies.
package mie_pkg;

  // Default datapath width for value and modulus.
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Width of the value and inverse ports, fixed by the interface.
  localparam int unsigned FIELD_W = 64;

  // APB port geometry: one 64-bit register, eight-byte address stride.
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;

  // Register index held in the address bits above the byte offset.
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture a new value and the modulus, start Euclid.
    logic shift;   // Double the aligned divisor.
    logic sub;     // One restoring-division step, with a swap on the last bit.
    logic finish;  // Write the result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_bad;   // Value is zero or not below the modulus.
    logic b_zero;      // Remainder reached zero: Euclid is done.
    logic align_more;  // Divisor can be doubled and still fit under the dividend.
    logic k_zero;      // Current division step handles the lowest quotient bit.
    logic out_free;    // Output register can take a result this cycle.
  } status_t;

endpackage

### hdl/modular_inverse_euclid.sv
// Modular inverse of a 64-bit residue by the extended Euclidean algorithm.
// Top level: APB register, controller and datapath. Depends on mie_pkg,
// mie_ctrl and mie_datapath.
//
// Write the modulus at address 0, then send values. Each value returns one
// beat: its inverse modulo the modulus and an invertible flag (inverse 0 and
// flag 0 when the value is zero, not below the modulus, or shares a factor
// with it). Only the low DATA_WIDTH bits of value and modulus are used. One
// item is in work at a time. The inverse is found by shift-subtract division
// of each Euclid quotient in one shared subtractor pair: a quotient takes
// alignment steps, subtract steps and one check step; one more check step
// finds the zero remainder, and load and result take one step each. A value
// that is rejected at once goes from load straight to result. A stalled
// result beat holds the block in its result state. The output register
// lets a finished beat wait while the next value is accepted.
module modular_inverse_euclid #(
  parameter int unsigned DATA_WIDTH = mie_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mie_pkg::FIELD_W-1:0]      value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mie_pkg::FIELD_W-1:0]      inverse_o,
  output logic                             invertible_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mie_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mie_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mie_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [DATA_WIDTH-1:0] modulus_q;
  logic [DATA_WIDTH-1:0] inverse;
  logic                  reg_hit;
  mie_pkg::cmd_t         cmd;
  mie_pkg::status_t      status;

  // The register index sits above the eight-byte offset.
  assign reg_hit = (paddr[mie_pkg::APB_ADDR_W-1] == mie_pkg::REG_MODULUS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? mie_pkg::APB_DATA_W'(modulus_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= DATA_WIDTH'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      modulus_q <= pwdata[DATA_WIDTH-1:0];
    end
  end

  mie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mie_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i[DATA_WIDTH-1:0]),
    .modulus_i    (modulus_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inverse_o    (inverse),
    .invertible_o (invertible_o)
  );

  assign inverse_o = mie_pkg::FIELD_W'(inverse);

endmodule

### hdl/mie_ctrl.sv
// Controller of the modular inverse block: sequences loading, divisor alignment,
// shift-subtract quotient steps and result delivery. Depends on mie_pkg.
module mie_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mie_pkg::status_t status_i,
  output mie_pkg::cmd_t    cmd_o
);

  mie_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mie_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mie_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.start_bad ? mie_pkg::ST_FINISH : mie_pkg::ST_ALIGN;
        end
      end
      mie_pkg::ST_ALIGN: begin
        if (status_i.b_zero) begin
          state_d = mie_pkg::ST_FINISH;
        end else if (status_i.align_more) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = mie_pkg::ST_SUB;
        end
      end
      mie_pkg::ST_SUB: begin
        cmd_o.sub = 1'b1;
        if (status_i.k_zero) begin
          state_d = mie_pkg::ST_ALIGN;
        end
      end
      mie_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mie_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/mie_datapath.sv
// Datapath of the modular inverse block: remainder and cofactor registers,
// one shared subtractor pair for shift-subtract division, and the output register.
// Depends on mie_pkg.
module mie_datapath #(
  parameter int unsigned DATA_WIDTH = mie_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] modulus_i,
  input  mie_pkg::cmd_t         cmd_i,
  output mie_pkg::status_t      status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] inverse_o,
  output logic                  invertible_o
);

  // Cofactors never exceed the modulus in magnitude, so one sign bit is enough.
  localparam int unsigned CW = DATA_WIDTH + 1;
  localparam int unsigned KW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] a_q, b_q, d_q, t_q;
  logic [CW-1:0]         ca_q, cb_q;
  logic [KW-1:0]         k_q;
  logic                  bad_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic                  ok_q;

  logic [DATA_WIDTH-1:0] d_dbl, a_sub, a_next;
  logic [CW-1:0]         c_shift, c_sub, c_next, c_fix;
  logic                  take, ok;
  logic [DATA_WIDTH-1:0] res;

  always_comb begin
    d_dbl   = {d_q[DATA_WIDTH-2:0], 1'b0};
    take    = (d_q <= a_q);
    a_sub   = a_q - d_q;
    c_shift = cb_q << k_q;
    c_sub   = ca_q - c_shift;
    a_next  = take ? a_sub : a_q;
    c_next  = take ? c_sub : ca_q;

    // A negative cofactor is brought into range by adding the modulus.
    c_fix   = ca_q[CW-1] ? (ca_q + {1'b0, t_q}) : ca_q;
    ok      = !bad_q && (a_q == DATA_WIDTH'(1));
    res     = ok ? c_fix[DATA_WIDTH-1:0] : '0;

    status_o.start_bad  = (modulus_i == '0) || (value_i >= modulus_i) || (value_i == '0);
    status_o.b_zero     = (b_q == '0);
    status_o.align_more = !d_q[DATA_WIDTH-1] && (d_dbl <= a_q);
    status_o.k_zero     = (k_q == '0);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= modulus_i;
      b_q   <= value_i;
      d_q   <= value_i;
      t_q   <= modulus_i;
      ca_q  <= '0;
      cb_q  <= CW'(1);
      k_q   <= '0;
      bad_q <= status_o.start_bad;
    end else if (cmd_i.shift) begin
      d_q <= d_dbl;
      k_q <= k_q + KW'(1);
    end else if (cmd_i.sub) begin
      if (k_q == '0) begin
        // Last quotient bit: the division step ends and the pairs rotate.
        a_q  <= b_q;
        b_q  <= a_next;
        d_q  <= a_next;
        ca_q <= cb_q;
        cb_q <= c_next;
      end else begin
        a_q  <= a_next;
        ca_q <= c_next;
        d_q  <= d_q >> 1;
        k_q  <= k_q - KW'(1);
      end
    end
    if (cmd_i.finish) begin
      res_q <= res;
      ok_q  <= ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inverse_o    = res_q;
  assign invertible_o = ok_q;

`ifndef SYNTHESIS
  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result written over an undelivered beat");

  a_load_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (k_q == '0))
    else $error("shift count not cleared at load");

  a_sub_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sub |-> (d_q != '0))
    else $error("division step with zero divisor");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && ok) |=> (res_q < t_q))
    else $error("inverse not reduced below modulus");
`endif

endmodule
